// ===== rtl/bec_pkg.sv =====
// Package for the battery EMA charge monitor: widths, register indexes,
// state-of-charge curve table. No dependencies.
`timescale 1ns / 1ps
package bec_pkg;
	localparam int VW = 21;
	localparam int CURVE_MAX = 32;
	localparam int CURVE_POINTS_DEF = 22;
	localparam logic [VW-1:0] V_MAX = 21'h1FFFFF;

	typedef enum logic [1:0] {
		REG_FAST_ALPHA = 2'd0,
		REG_SLOW_ALPHA = 2'd1,
		REG_MARGIN     = 2'd2,
		REG_DIVIDER    = 2'd3
	} reg_idx_t;

	function automatic logic [12:0] curve_mv(input logic [4:0] i);
		case (i)
			5'd0: curve_mv = 13'd4200;  5'd1: curve_mv = 13'd4150;
			5'd2: curve_mv = 13'd4110;  5'd3: curve_mv = 13'd4080;
			5'd4: curve_mv = 13'd4020;  5'd5: curve_mv = 13'd3980;
			5'd6: curve_mv = 13'd3950;  5'd7: curve_mv = 13'd3910;
			5'd8: curve_mv = 13'd3870;  5'd9: curve_mv = 13'd3850;
			5'd10: curve_mv = 13'd3840; 5'd11: curve_mv = 13'd3820;
			5'd12: curve_mv = 13'd3800; 5'd13: curve_mv = 13'd3790;
			5'd14: curve_mv = 13'd3770; 5'd15: curve_mv = 13'd3750;
			5'd16: curve_mv = 13'd3730; 5'd17: curve_mv = 13'd3710;
			5'd18: curve_mv = 13'd3690; 5'd19: curve_mv = 13'd3610;
			5'd20: curve_mv = 13'd3500; 5'd21: curve_mv = 13'd3300;
			default: curve_mv = 13'd0;
		endcase
	endfunction

	function automatic logic [6:0] curve_pct(input logic [4:0] i);
		case (i)
			5'd0: curve_pct = 7'd100; 5'd1: curve_pct = 7'd95;
			5'd2: curve_pct = 7'd90;  5'd3: curve_pct = 7'd85;
			5'd4: curve_pct = 7'd80;  5'd5: curve_pct = 7'd75;
			5'd6: curve_pct = 7'd70;  5'd7: curve_pct = 7'd65;
			5'd8: curve_pct = 7'd60;  5'd9: curve_pct = 7'd55;
			5'd10: curve_pct = 7'd50; 5'd11: curve_pct = 7'd45;
			5'd12: curve_pct = 7'd40; 5'd13: curve_pct = 7'd35;
			5'd14: curve_pct = 7'd30; 5'd15: curve_pct = 7'd25;
			5'd16: curve_pct = 7'd20; 5'd17: curve_pct = 7'd15;
			5'd18: curve_pct = 7'd10; 5'd19: curve_pct = 7'd5;
			5'd20: curve_pct = 7'd2;  5'd21: curve_pct = 7'd0;
			default: curve_pct = 7'd0;
		endcase
	endfunction
endpackage

// ===== rtl/battery_ema_charge_and_percent_top.sv =====
// Top level of the battery EMA charge monitor. Depends on bec_pkg,
// bec_sermul (serial multiplier) and bec_soc (curve interpolation).
//
// Usage: one input word (pin_millivolts, reading_ok) on in_valid/in_stall;
// one result word per input on out_valid/out_stall. Configuration is written
// through cfg_valid/cfg_ready/cfg_index/cfg_data; the user must write it only
// while idle, the block does not enforce this. cfg_ready is always high.
// One word at a time: input is taken when no result is in work. Steps to
// out_valid: the divider multiply, the fast and slow average updates, then a
// curve scan, a multiply, a rounding step, a divide and a capture step for
// the percent. A bad reading skips the divider multiply and the averages;
// one before any good reading goes straight to the output state. A voltage
// at a curve end skips the scan, multiply and divide; a first good reading
// skips the average updates. The next word is taken in the cycle after the
// result is accepted. Reset clears both averages, the have-reading and
// charging flags and restores register defaults. While the receiver stalls,
// the result holds in the output register and no new input is accepted.
`timescale 1ns / 1ps
module battery_ema_charge_and_percent_top import bec_pkg::*; #(
	parameter int CURVE_POINTS = CURVE_POINTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [11:0]   pin_millivolts,
	input  logic          reading_ok,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [6:0]    percent,
	output logic          percent_valid,
	output logic [20:0]   battery_voltage,
	output logic          charging,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [15:0]   cfg_data
);
	typedef enum logic [2:0] {T_IDLE, T_SCALE, T_FAST, T_SLOW, T_PCT, T_OUT, T_SOC} st_t;
	st_t st_q;
	logic [15:0] fa_q, sa_q, mg_q, dr_q;
	logic [VW-1:0] fast_q, slow_q, v_q;
	logic have_q, chg_q;

	logic m_start, m_done;
	logic [15:0] m_a;
	logic signed [22:0] m_b;
	logic signed [38:0] m_p;
	bec_sermul #(.AW(16), .BW(23)) u_mul (.clk, .arst_n, .start(m_start), .a(m_a),
		.b(m_b), .done(m_done), .prod(m_p));

	logic s_start, s_done;
	logic [6:0] s_pct;
	bec_soc #(.CURVE_POINTS(CURVE_POINTS)) u_soc (.clk, .arst_n, .start(s_start),
		.v(fast_q), .done(s_done), .pct(s_pct));

	logic [11:0] pin_q;
	assign cfg_ready = 1'b1;
	assign in_stall = (st_q != T_IDLE);

	logic [32:0] sc;
	assign sc = 33'(m_p) >> 6;
	logic [VW-1:0] vsat;
	assign vsat = (sc > 33'(V_MAX)) ? V_MAX : sc[VW-1:0];

	// fast delta taken from the scaled reading as it leaves the multiplier
	logic signed [22:0] dfast, dslow;
	assign dfast = $signed({2'b0, vsat}) - $signed({2'b0, fast_q});
	assign dslow = $signed({2'b0, v_q}) - $signed({2'b0, slow_q});
	logic [VW-1:0] upd;
	assign upd = VW'($signed({18'd0, (st_q == T_FAST) ? fast_q : slow_q}) + (m_p >>> 16));

	always_comb begin
		m_start = 1'b0; m_a = dr_q; m_b = 23'(pin_q);
		s_start = 1'b0;
		case (st_q)
			T_IDLE: begin
				m_start = in_valid && reading_ok && have_q;
				m_a = dr_q; m_b = 23'(pin_millivolts);
			end
			T_SCALE: begin m_start = m_done && have_q; m_a = fa_q; m_b = dfast; end
			T_FAST: begin m_start = m_done; m_a = sa_q; m_b = dslow; end
			default: ;
		endcase
		if (st_q == T_SLOW && m_done) s_start = 1'b1;
		if (st_q == T_IDLE && in_valid && !(reading_ok) && have_q) s_start = 1'b1;
		if (st_q == T_IDLE && in_valid && reading_ok && !have_q) m_start = 1'b1;
		if (st_q == T_SOC) s_start = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= T_IDLE;
			out_valid <= 1'b0;
			fa_q <= 16'd13107; sa_q <= 16'd1311; mg_q <= 16'd2560; dr_q <= 16'd27525;
			fast_q <= '0; slow_q <= '0; have_q <= 1'b0; chg_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_FAST_ALPHA: fa_q <= cfg_data;
					REG_SLOW_ALPHA: sa_q <= cfg_data;
					REG_MARGIN:     mg_q <= cfg_data;
					REG_DIVIDER:    dr_q <= cfg_data;
					default: ;
				endcase
			end
			case (st_q)
				T_IDLE: if (in_valid) begin
					pin_q <= pin_millivolts;
					if (reading_ok) st_q <= T_SCALE;
					else if (have_q) st_q <= T_PCT;
					else st_q <= T_OUT;
				end
				T_SCALE: if (m_done) begin
					v_q <= vsat;
					if (!have_q) begin
						fast_q <= vsat; slow_q <= vsat; have_q <= 1'b1;
						st_q <= T_SOC;
					end else st_q <= T_FAST;
				end
				T_SOC: st_q <= T_PCT;
				T_FAST: if (m_done) begin fast_q <= upd; st_q <= T_SLOW; end
				T_SLOW: if (m_done) begin
					slow_q <= upd;
					if (fast_q > upd && fast_q - upd > VW'(mg_q)) chg_q <= 1'b1;
					else if (upd > fast_q && upd - fast_q > VW'(mg_q)) chg_q <= 1'b0;
					st_q <= T_PCT;
				end
				T_PCT: if (s_done) begin
					percent <= s_pct; percent_valid <= 1'b1;
					battery_voltage <= fast_q; charging <= chg_q;
					out_valid <= 1'b1; st_q <= T_OUT;
				end
				T_OUT: begin
					if (!out_valid) begin
						percent <= '0; percent_valid <= 1'b0;
						battery_voltage <= '0; charging <= chg_q;
						out_valid <= 1'b1;
					end else if (!out_stall) begin
						out_valid <= 1'b0; st_q <= T_IDLE;
					end
				end
				default: st_q <= T_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> st_q == T_OUT) else $error("result word outside output state");
	a_have: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(have_q) |-> 1'b0) else $error("have flag dropped");
	a_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while result pending");
`endif
endmodule

// ===== rtl/bec_sermul.sv =====
// Bit-serial shift-add multiplier: unsigned a times signed/unsigned b,
// one bit of a per cycle. Imports bec_pkg but uses nothing from it.
`timescale 1ns / 1ps
module bec_sermul import bec_pkg::*; #(
	parameter int AW = 16,
	parameter int BW = 23,
	parameter int PW = AW + BW
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [AW-1:0]        a,
	input  logic signed [BW-1:0] b,
	output logic                 done,
	output logic signed [PW-1:0] prod
);
	localparam int CW = $clog2(AW + 1);
	logic [AW-1:0] a_q;
	logic signed [PW-1:0] b_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(AW);
				a_q <= a;
				b_q <= PW'(b);
				prod <= '0;
			end else if (busy_q) begin
				if (a_q[0]) prod <= prod + b_q;
				a_q <= a_q >> 1;
				b_q <= b_q <<< 1;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
endmodule

// ===== rtl/bec_soc.sv =====
// State-of-charge interpolation: walks the curve one segment per cycle,
// then serial-multiplies and divides restoring one bit per cycle. Uses bec_pkg.
`timescale 1ns / 1ps
module bec_soc import bec_pkg::*; #(
	parameter int CURVE_POINTS = CURVE_POINTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [VW-1:0] v,
	output logic          done,
	output logic [6:0]    pct
);
	localparam int NP = (CURVE_POINTS < 2) ? 2 :
		((CURVE_POINTS > CURVE_MAX) ? CURVE_MAX : CURVE_POINTS);
	localparam logic [4:0] LAST = 5'(NP - 1);
	// num = dp*(v-lo)*2+den < 2^33; den < 2^22
	localparam int NW = 34;

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_MUL, S_DIV, S_FIN} st_t;
	st_t st_q;
	logic [4:0] i_q;
	logic [6:0] plo_q, dp_q;
	logic [VW:0] den_q, dv_q, rem_q;
	logic [NW-1:0] num_q;
	logic [5:0] cnt_q;

	logic [VW:0] hi, lo;
	logic [6:0] phi, plo;
	assign hi = {1'b0, curve_mv(i_q), 8'd0};
	assign lo = {1'b0, curve_mv(i_q + 5'd1), 8'd0};
	assign phi = curve_pct(i_q);
	assign plo = curve_pct(i_q + 5'd1);
	logic [VW+2:0] trial;
	assign trial = {1'b0, rem_q, num_q[NW-1]} - {1'b0, den_q, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			done <= 1'b0;
			i_q <= '0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			case (st_q)
				S_IDLE: if (start) begin
					i_q <= '0;
					if ({1'b0, v} >= {1'b0, curve_mv(5'd0), 8'd0}) begin
						pct <= 7'd100; done <= 1'b1;
					end else if ({1'b0, v} <= {1'b0, curve_mv(LAST), 8'd0}) begin
						pct <= 7'd0; done <= 1'b1;
					end else st_q <= S_SCAN;
				end
				S_SCAN: begin
					if ({1'b0, v} <= hi && {1'b0, v} >= lo) begin
						if (hi == lo || phi < plo) begin
							pct <= (hi == lo) ? phi : plo;
							done <= 1'b1;
							st_q <= S_IDLE;
						end else begin
							plo_q <= plo;
							dp_q <= phi - plo;
							den_q <= hi - lo;
							dv_q <= {1'b0, v} - lo;
							num_q <= '0;
							cnt_q <= 6'd7;
							st_q <= S_MUL;
						end
					end else if (i_q + 5'd1 >= LAST) begin
						pct <= 7'd0; done <= 1'b1; st_q <= S_IDLE;
					end else i_q <= i_q + 5'd1;
				end
				S_MUL: begin
					// shift-add over dp bits, msb first
					num_q <= (num_q << 1) + (dp_q[6] ? NW'(dv_q) : '0);
					dp_q <= dp_q << 1;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == 6'd1) st_q <= S_FIN;
				end
				S_FIN: begin
					num_q <= (num_q << 1) + NW'(den_q);
					rem_q <= '0;
					cnt_q <= 6'(NW);
					st_q <= S_DIV;
				end
				S_DIV: begin
					// restoring divide by 2*den; quotient bits shift into num_q
					if (!trial[VW+2]) begin
						rem_q <= trial[VW:0];
						num_q <= {num_q[NW-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[VW-1:0], num_q[NW-1]};
						num_q <= {num_q[NW-2:0], 1'b0};
					end
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == 6'd1) st_q <= S_IDLE;
					if (cnt_q == 6'd1) done <= 1'b1;
					if (cnt_q == 6'd1)
						pct <= 7'(plo_q + (trial[VW+2] ? {num_q[5:0], 1'b0} :
							{num_q[5:0], 1'b1}));
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== tb/sv/tb_battery_ema_charge_and_percent_top.sv =====
// Testbench for the battery EMA charge monitor: predicts scaled voltage,
// fast/slow averages, charging hysteresis and curve percent per word.
// Depends on bec_pkg and battery_ema_charge_and_percent_top.
`timescale 1ns / 1ps
module tb_battery_ema_charge_and_percent_top;
	import bec_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int NPTS = 22;

	typedef struct packed {
		logic [6:0]  pct;
		logic        pvalid;
		logic [20:0] volt;
		logic        chg;
	} soc_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [11:0] pin_millivolts = '0;
	logic        reading_ok = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [6:0]  percent;
	logic        percent_valid;
	logic [20:0] battery_voltage;
	logic        charging;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// predictor state
	int unsigned m_fast_alpha, m_slow_alpha, m_margin, m_divider;
	int unsigned m_fast, m_slow;
	bit          m_have, m_chg;

	soc_word_t expected_words[$];
	int        errors = 0;
	int        idle_cycles = 0;
	bit        stall_mode = 1'b1;

	battery_ema_charge_and_percent_top i_dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// soc curve in mV (local copy, not the package function)
	function automatic int unsigned curve_point_mv(int i);
		int unsigned t [NPTS] = '{4200, 4150, 4110, 4080, 4020, 3980, 3950, 3910,
			3870, 3850, 3840, 3820, 3800, 3790, 3770, 3750, 3730, 3710, 3690,
			3610, 3500, 3300};
		return t[i];
	endfunction

	function automatic int unsigned curve_point_pct(int i);
		int unsigned t [NPTS] = '{100, 95, 90, 85, 80, 75, 70, 65, 60, 55, 50,
			45, 40, 35, 30, 25, 20, 15, 10, 5, 2, 0};
		return t[i];
	endfunction

	function automatic int unsigned ema_step(int unsigned avg, int unsigned v,
			int unsigned alpha);
		longint p;
		p = (longint'(v) - longint'(avg)) * longint'(alpha);
		return int'(longint'(avg) + (p >>> 16));
	endfunction

	function automatic int unsigned soc_percent(int unsigned vq);
		longint unsigned hi, lo, den, num, r;
		int unsigned phi, plo;
		if (vq >= curve_point_mv(0) * 256) return 100;
		if (vq <= curve_point_mv(NPTS - 1) * 256) return 0;
		for (int i = 0; i + 1 < NPTS; i++) begin
			hi = curve_point_mv(i) * 256;
			lo = curve_point_mv(i + 1) * 256;
			if (vq <= hi && vq >= lo) begin
				phi = curve_point_pct(i);
				plo = curve_point_pct(i + 1);
				if (hi == lo) return phi > 100 ? 100 : phi;
				if (phi < plo) return plo > 100 ? 100 : plo;
				den = hi - lo;
				num = longint'(phi - plo) * (vq - lo) * 2 + den;
				r = plo + num / (2 * den);
				return r > 100 ? 100 : int'(r);
			end
		end
		return 0;
	endfunction

	function automatic soc_word_t predict_reading(logic [11:0] pin, logic ok);
		longint unsigned s;
		int unsigned v;
		soc_word_t w;
		if (ok) begin
			s = (longint'(pin) * m_divider) >> 6;
			v = (s > 2097151) ? 2097151 : int'(s);
			if (!m_have) begin
				m_fast = v;
				m_slow = v;
				m_have = 1'b1;
			end else begin
				m_fast = ema_step(m_fast, v, m_fast_alpha);
				m_slow = ema_step(m_slow, v, m_slow_alpha);
				if (m_fast > m_slow && m_fast - m_slow > m_margin) m_chg = 1'b1;
				else if (m_slow > m_fast && m_slow - m_fast > m_margin) m_chg = 1'b0;
			end
		end
		w.pct = m_have ? 7'(soc_percent(m_fast)) : '0;
		w.pvalid = m_have;
		w.volt = m_have ? 21'(m_fast) : '0;
		w.chg = m_chg;
		return w;
	endfunction

	task automatic send_reading(logic [11:0] pin, logic ok);
		expected_words.push_back(predict_reading(pin, ok));
		in_valid <= 1'b1;
		pin_millivolts <= pin;
		reading_ok <= ok;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic idle_gap(int n);
		in_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_FAST_ALPHA: m_fast_alpha = data;
			REG_SLOW_ALPHA: m_slow_alpha = data;
			REG_MARGIN:     m_margin = data;
			REG_DIVIDER:    m_divider = data;
			default: ;
		endcase
	endtask

	task automatic set_regs(logic [15:0] fa, logic [15:0] sa, logic [15:0] mg,
			logic [15:0] dv);
		drain();
		write_reg(REG_FAST_ALPHA, fa);
		write_reg(REG_SLOW_ALPHA, sa);
		write_reg(REG_MARGIN, mg);
		write_reg(REG_DIVIDER, dv);
	endtask

	// bad readings before the first good one, extremes, saturation
	task automatic test_directed();
		send_reading(12'd0, 1'b0);
		send_reading(12'hFFF, 1'b0);
		send_reading(12'd2500, 1'b1);
		send_reading(12'd0, 1'b0);
		send_reading(12'hFFF, 1'b1);
		send_reading(12'd0, 1'b1);
		send_reading(12'hFFF, 1'b1);
		send_reading(12'hFFF, 1'b1);
		// extreme gain saturates the scaled voltage
		set_regs(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
		send_reading(12'hFFF, 1'b1);
		send_reading(12'd0, 1'b1);
		send_reading(12'd1, 1'b1);
		send_reading(12'hFFF, 1'b1);
		set_regs(16'd0, 16'd0, 16'hFFFF, 16'd0);
		send_reading(12'd1234, 1'b1);
		send_reading(12'hAAA, 1'b1);
		set_regs(16'd13107, 16'd1311, 16'd2560, 16'd27525);
	endtask

	// sweep across the curve and exact curve points (divider 1.0 at Q2.14)
	task automatic test_curve_points();
		set_regs(16'hFFFF, 16'd0, 16'd0, 16'd16384);
		for (int i = 0; i < NPTS; i += 3)
			send_reading(12'(curve_point_mv(i)), 1'b1);
		send_reading(12'd3301, 1'b1);
		send_reading(12'd4199, 1'b1);
		set_regs(16'd13107, 16'd1311, 16'd2560, 16'd27525);
	endtask

	// mode 0 ramps up and down so the hysteresis sets and clears; other modes send random readings
	task automatic test_random_phase(int n, int mode);
		int unsigned pin;
		int burst;
		pin = $urandom_range(1960, 2500);
		burst = $urandom_range(1, 20);
		for (int k = 0; k < n; k++) begin
			if (mode == 0 && $urandom_range(0, 9) < 8) begin
				pin = (k / 60) % 2 ? pin - $urandom_range(0, 12) :
					pin + $urandom_range(0, 12);
				if (pin > 4095) pin = $urandom_range(0, 4095);
			end else begin
				pin = $urandom_range(0, 4095);
			end
			send_reading(12'(pin), $urandom_range(0, 9) != 0);
			if (--burst == 0) begin
				burst = $urandom_range(1, 20);
				if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 30));
			end
		end
	endtask

	task automatic test_random();
		test_random_phase(400, 0);
		set_regs(16'($urandom), 16'($urandom_range(0, 4000)),
			16'($urandom_range(0, 4000)), 16'($urandom));
		test_random_phase(300, 1);
		// hold off until the pipeline is empty, then resume
		drain();
		set_regs(16'($urandom_range(20000, 65535)), 16'($urandom_range(0, 2000)),
			16'($urandom_range(0, 1500)), 16'($urandom_range(20000, 32000)));
		test_random_phase(350, 0);
		set_regs(16'd13107, 16'd1311, 16'd2560, 16'd27525);
		test_random_phase(350, 0);
	endtask

	// receiver stall pattern: alternating open and choppy stretches
	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
		out_stall <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b0;
	end

	always @(posedge clk) begin
		soc_word_t exp_w, got;
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (out_valid && !out_stall && arst_n) begin
			got = '{percent, percent_valid, battery_voltage, charging};
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word %h", $time, got);
				errors++;
			end else begin
				exp_w = expected_words.pop_front();
				if (got.pct !== exp_w.pct) begin
					$display("%0t: percent exp %0d got %0d", $time, exp_w.pct, got.pct);
					errors++;
				end
				if (got.pvalid !== exp_w.pvalid) begin
					$display("%0t: percent_valid exp %0d got %0d", $time,
						exp_w.pvalid, got.pvalid);
					errors++;
				end
				if (got.volt !== exp_w.volt) begin
					$display("%0t: battery_voltage exp %0d got %0d", $time,
						exp_w.volt, got.volt);
					errors++;
				end
				if (got.chg !== exp_w.chg) begin
					$display("%0t: charging exp %0d got %0d", $time, exp_w.chg, got.chg);
					errors++;
				end
			end
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		m_fast_alpha = 13107;
		m_slow_alpha = 1311;
		m_margin = 2560;
		m_divider = 27525;
		m_fast = 0;
		m_slow = 0;
		m_have = 1'b0;
		m_chg = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_curve_points();
		test_random();
		drain();
		if (errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule
